@@ hw/rtl/ppvd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppvd_pkg: shared definitions of the punch peak/valley detector
// Types, codes and reset values for the files of the block.
// ----------------------------------------------------------------------------
package ppvd_pkg;

  localparam int WINDOW_LEN_DEFAULT  = 99;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  localparam int CfgDataBits   = 23;
  localparam int CfgLevelBits  = 23;
  localparam int CfgTickBits   = 16;
  localparam int TimeBits      = 32;

  localparam logic [CfgLevelBits-1:0] PeakThresholdReset = 23'd100;
  localparam logic [CfgLevelBits-1:0] ValleyFloorReset   = 23'd10;
  localparam logic [CfgTickBits-1:0]  HoldoffReset       = 16'd260;
  localparam logic [CfgTickBits-1:0]  ValleyMarginReset  = 16'd50;

  localparam int LastPeakReset = 200;
  localparam int SwingDivisor  = 10;

  typedef enum logic [1:0] {
    CFG_PEAK_THRESHOLD = 2'd0,
    CFG_VALLEY_FLOOR   = 2'd1,
    CFG_HOLDOFF_TICKS  = 2'd2,
    CFG_VALLEY_MARGIN  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_START_PEAK  = 2'd0,
    PH_DETECT_PEAK = 2'd1,
    PH_START_MIN   = 2'd2,
    PH_DETECT_MIN  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DECIDE,
    ST_TENTH_GO,
    ST_TENTH
  } ctl_state_e;

  typedef struct packed {
    logic [CfgLevelBits-1:0] peak_threshold;
    logic [CfgLevelBits-1:0] valley_floor;
    logic [CfgTickBits-1:0]  holdoff_ticks;
    logic [CfgTickBits-1:0]  valley_margin;
  } cfg_t;

  typedef struct packed {
    logic peak;
    logic valley;
  } det_flags_t;

endpackage

@@ hw/rtl/ppvd_if.sv @@
// ----------------------------------------------------------------------------
// ppvd_if: channel interfaces of the punch peak/valley detector
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ppvd_in_if
  import ppvd_pkg::*;
#(
  parameter int SampleBits = SAMPLE_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_value;
  logic [TimeBits-1:0]          time_stamp;

  modport source (output valid, sample_value, time_stamp, input ready);
  modport sink   (input valid, sample_value, time_stamp, output ready);
endinterface

interface ppvd_out_if
  import ppvd_pkg::*;
#(
  parameter int SampleBits = SAMPLE_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] delayed_sample;
  logic signed [SampleBits-1:0] window_average;
  logic                         peak_found;
  logic                         valley_found;

  modport source (output valid, delayed_sample, window_average, peak_found, valley_found,
                  input ready);
  modport sink   (input valid, delayed_sample, window_average, peak_found, valley_found,
                  output ready);
endinterface

interface ppvd_cfg_if
  import ppvd_pkg::*;
;
  logic                   valid;
  logic                   ready;
  cfg_idx_e               index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ppvd_window_ram.sv @@
// ----------------------------------------------------------------------------
// ppvd_window_ram: sample window store
// One write port and two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module ppvd_window_ram
  import ppvd_pkg::*;
#(
  parameter int Depth     = WINDOW_LEN_DEFAULT,
  parameter int DataBits  = SAMPLE_BITS_DEFAULT,
  parameter int AddrBits  = $clog2(WINDOW_LEN_DEFAULT)
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr0_i,
  input  logic [AddrBits-1:0] raddr1_i,
  output logic [DataBits-1:0] rdata0_o,
  output logic [DataBits-1:0] rdata1_o
);

  logic [DataBits-1:0] mem [Depth];
  logic [DataBits-1:0] rdata0_q, rdata1_q;

  // Both reads see the contents from before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_q      <= mem[raddr0_i];
      rdata1_q      <= mem[raddr1_i];
      mem[waddr_i]  <= wdata_i;
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ hw/rtl/ppvd_divider.sv @@
// ----------------------------------------------------------------------------
// ppvd_divider: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module ppvd_divider
  import ppvd_pkg::*;
#(
  parameter int DividendBits = 31,
  parameter int DivisorBits  = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DividendBits-1:0] dividend_i,
  input  logic [DivisorBits-1:0]  divisor_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [DividendBits-1:0] quotient_o
);

  localparam int CntBits = $clog2(DividendBits + 1);

  logic                    busy_q, busy_d, done_q, done_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic [DividendBits-1:0] quo_q, quo_d;
  logic [DivisorBits-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [DivisorBits:0]    rem_sh;
  logic                    ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DividendBits-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DividendBits);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendBits-2:0], ge};
      rem_d = ge ? DivisorBits'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivisorBits-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hw/rtl/ppvd_detector.sv @@
// ----------------------------------------------------------------------------
// ppvd_detector: four-phase peak/valley machine
// Compares the delayed sample with the window average and tracks extremes.
// ----------------------------------------------------------------------------
module ppvd_detector
  import ppvd_pkg::*;
#(
  parameter int SampleBits = SAMPLE_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         update_i,
  input  logic signed [SampleBits-1:0] z_i,
  input  logic signed [SampleBits-1:0] avg_i,
  input  logic [SampleBits:0]          tenth_i,
  input  logic [TimeBits-1:0]          ts_i,
  input  cfg_t                         cfg_i,
  output det_flags_t                   flags_o,
  output logic [SampleBits:0]          swing_o
);

  localparam int Cw = ((SampleBits > CfgLevelBits) ? SampleBits : CfgLevelBits) + 4;

  phase_e                     phase_q, phase_d;
  logic signed [SampleBits:0] last_peak_q, last_peak_d;
  logic signed [SampleBits-1:0] last_valley_q, last_valley_d;
  logic [SampleBits:0]        swing_q, swing_d;
  logic [TimeBits-1:0]        start_time_q, start_time_d;

  logic signed [Cw-1:0] zx, ax, tx, lpx, lvx, thr, flr, mrg, diff;
  logic [TimeBits-1:0]  elapsed;
  logic                 start_ok, above_peak, below_avg, valley_start;
  logic                 below_valley, valley_end;

  always_comb begin
    zx  = Cw'(z_i);
    ax  = Cw'(avg_i);
    tx  = Cw'(signed'({1'b0, tenth_i}));
    lpx = Cw'(last_peak_q);
    lvx = Cw'(last_valley_q);
    thr = Cw'(signed'({1'b0, cfg_i.peak_threshold}));
    flr = Cw'(signed'({1'b0, cfg_i.valley_floor}));
    mrg = Cw'(signed'({1'b0, cfg_i.valley_margin}));
    elapsed      = ts_i - start_time_q;
    start_ok     = (elapsed > TimeBits'(cfg_i.holdoff_ticks)) && (zx > ax + tx) && (zx > thr);
    above_peak   = zx > lpx;
    below_avg    = zx < ax;
    valley_start = zx < ax - mrg;
    below_valley = zx < lvx;
    valley_end   = !below_valley && ((zx > lvx + mrg) || (zx < flr));
    diff         = above_peak ? zx - lpx : lpx - zx;
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (update_i) begin
      unique case (phase_q)
        PH_START_PEAK:  if (start_ok) phase_d = PH_DETECT_PEAK;
        PH_DETECT_PEAK: if (!above_peak && below_avg) phase_d = PH_START_MIN;
        PH_START_MIN:   if (valley_start) phase_d = PH_DETECT_MIN;
        PH_DETECT_MIN:  if (valley_end) phase_d = PH_START_PEAK;
        default:        phase_d = PH_START_PEAK;
      endcase
    end
  end

  // Flags and tracked extremes.
  always_comb begin
    flags_o.peak   = (phase_q == PH_START_PEAK) && start_ok;
    flags_o.valley = (phase_q == PH_DETECT_MIN) && valley_end;
    last_peak_d    = last_peak_q;
    last_valley_d  = last_valley_q;
    swing_d        = swing_q;
    start_time_d   = start_time_q;
    if (update_i) begin
      unique case (phase_q)
        PH_START_PEAK: begin
          if (start_ok) begin
            start_time_d = ts_i;
            swing_d      = diff[SampleBits:0];
            last_peak_d  = (SampleBits+1)'(z_i);
          end
        end
        PH_DETECT_PEAK: if (above_peak) last_peak_d = (SampleBits+1)'(z_i);
        PH_START_MIN:   if (valley_start) last_valley_d = z_i;
        PH_DETECT_MIN:  if (below_valley) last_valley_d = z_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START_PEAK;
      last_peak_q  <= (SampleBits+1)'(LastPeakReset);
      last_valley_q <= '0;
      swing_q      <= '0;
      start_time_q <= '0;
    end else begin
      phase_q      <= phase_d;
      last_peak_q  <= last_peak_d;
      last_valley_q <= last_valley_d;
      swing_q      <= swing_d;
      start_time_q <= start_time_d;
    end
  end

  assign swing_o = swing_q;

endmodule

@@ hw/rtl/punch_peak_valley_detector_core.sv @@
// ----------------------------------------------------------------------------
// punch_peak_valley_detector_core: punch peak/valley detector
// Moving-window average, centered delay and a peak/valley state machine.
// ----------------------------------------------------------------------------
// The block takes one sample beat at a time and returns exactly one result
// beat for it. An accepted sample goes through ST_LOAD (sum update, divider
// start), ST_DIV (wait for the window average) and ST_DECIDE (wait for a free
// output register, then load the result); no new sample is taken until the
// block is back in ST_IDLE. SumBits = SampleBits + clog2(WindowLen + 1) is
// the running sum width (31 bits with the default 99-entry window and 24-bit
// samples); the bit-serial divider forms the window average one quotient bit
// per cycle. When an item accepts a peak start, the same divider then works
// out a tenth of the new peak swing before the next sample is taken. A
// finished result sits in an output register, so the next sample can be
// accepted while it waits. The window store needs no clearing pass after
// reset: the only entry ever read before being written is the one read by
// the very first sample, which is forced to zero. Register writes are
// accepted in any cycle and should be made while the block is idle.
module punch_peak_valley_detector_core
  import ppvd_pkg::*;
#(
  parameter int WindowLen  = WINDOW_LEN_DEFAULT,
  parameter int SampleBits = SAMPLE_BITS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppvd_in_if.sink    in_i,
  ppvd_out_if.source out_o,
  ppvd_cfg_if.sink   cfg_i
);

  localparam int FillBits = $clog2(WindowLen + 1);
  localparam int AddrBits = $clog2(WindowLen);
  localparam int SumBits  = SampleBits + FillBits;
  localparam int DivBits  = (FillBits > 4) ? FillBits : 4;
  localparam int Half     = WindowLen / 2;

  // Configuration registers. The write channel never stalls.
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_threshold <= PeakThresholdReset;
      cfg_q.valley_floor   <= ValleyFloorReset;
      cfg_q.holdoff_ticks  <= HoldoffReset;
      cfg_q.valley_margin  <= ValleyMarginReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_PEAK_THRESHOLD: cfg_q.peak_threshold <= cfg_i.data[CfgLevelBits-1:0];
        CFG_VALLEY_FLOOR:   cfg_q.valley_floor   <= cfg_i.data[CfgLevelBits-1:0];
        CFG_HOLDOFF_TICKS:  cfg_q.holdoff_ticks  <= cfg_i.data[CfgTickBits-1:0];
        CFG_VALLEY_MARGIN:  cfg_q.valley_margin  <= cfg_i.data[CfgTickBits-1:0];
        default: ;
      endcase
    end
  end

  // Control state and window bookkeeping.
  ctl_state_e           state_q, state_d;
  logic [FillBits-1:0]  fill_q, fill_d;
  logic [AddrBits-1:0]  slot_q, slot_d;
  logic signed [SumBits-1:0] sum_q, sum_d;
  logic                 out_valid_q, out_valid_d;

  // Per-item datapath registers.
  logic signed [SampleBits-1:0] samp_q;
  logic [TimeBits-1:0]          ts_q;
  logic                         first_q, filling_q, neg_q;
  logic signed [SampleBits-1:0] z_q;
  logic [SampleBits:0]          tenth_q;
  logic signed [SampleBits-1:0] out_z_q, out_avg_q;
  det_flags_t                   out_flags_q;

  logic                  accept, filling, out_free;
  logic                  in_ready, div_start, det_update;
  logic [AddrBits-1:0]   waddr, raddr0;
  logic [AddrBits:0]     mid_sum;
  logic [SampleBits-1:0] rd0, rd1;
  logic signed [SampleBits-1:0] old_samp, avg;
  logic [SumBits-1:0]    div_dividend;
  logic [DivBits-1:0]    div_divisor;
  logic                  div_busy, div_done;
  logic [SumBits-1:0]    div_quo;
  logic [SampleBits-1:0] quo_lo;
  det_flags_t            det_flags;
  logic [SampleBits:0]   det_swing;

  assign accept   = in_i.valid && in_ready;
  assign filling  = fill_q < FillBits'(WindowLen);
  assign out_free = !out_valid_q || out_o.ready;

  // While filling, the delayed sample is the entry halfway up the filled
  // part; once full, it sits half a window ahead of the oldest slot.
  always_comb begin
    mid_sum = {1'b0, slot_q} + (AddrBits+1)'(Half);
    if (mid_sum >= (AddrBits+1)'(WindowLen)) begin
      mid_sum = mid_sum - (AddrBits+1)'(WindowLen);
    end
    raddr0 = filling ? AddrBits'(fill_q >> 1) : mid_sum[AddrBits-1:0];
    waddr  = filling ? fill_q[AddrBits-1:0] : slot_q;
  end

  ppvd_window_ram #(
    .Depth    (WindowLen),
    .DataBits (SampleBits),
    .AddrBits (AddrBits)
  ) u_ram (
    .clk_i    (clk_i),
    .en_i     (accept),
    .waddr_i  (waddr),
    .wdata_i  (in_i.sample_value),
    .raddr0_i (raddr0),
    .raddr1_i (slot_q),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_i.valid) state_d = ST_LOAD;
      ST_LOAD:     state_d = ST_DIV;
      ST_DIV:      if (div_done) state_d = ST_DECIDE;
      ST_DECIDE:   if (out_free) state_d = det_flags.peak ? ST_TENTH_GO : ST_IDLE;
      ST_TENTH_GO: state_d = ST_TENTH;
      ST_TENTH:    if (div_done) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    det_update   = 1'b0;
    div_dividend = SumBits'(det_swing);
    div_divisor  = DivBits'(SwingDivisor);
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: begin
        div_start    = 1'b1;
        div_dividend = sum_d[SumBits-1] ? SumBits'(-sum_d) : SumBits'(sum_d);
        div_divisor  = DivBits'(fill_d);
      end
      ST_DECIDE:   det_update = out_free;
      ST_TENTH_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  // The running sum drops the sample leaving the window once it is full.
  always_comb begin
    old_samp = filling_q ? '0 : signed'(rd1);
    sum_d    = sum_q;
    fill_d   = fill_q;
    slot_d   = slot_q;
    if (state_q == ST_LOAD) begin
      sum_d = sum_q + SumBits'(samp_q) - SumBits'(old_samp);
      if (filling_q) begin
        fill_d = fill_q + 1'b1;
      end else begin
        slot_d = (slot_q == AddrBits'(WindowLen - 1)) ? '0 : slot_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (det_update) begin
      out_valid_d = 1'b1;
    end
  end

  ppvd_divider #(
    .DividendBits (SumBits),
    .DivisorBits  (DivBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // The quotient magnitude always fits the sample width; the sign of the
  // sum is put back so the average truncates toward zero.
  assign quo_lo = div_quo[SampleBits-1:0];
  assign avg    = neg_q ? signed'(-quo_lo) : signed'(quo_lo);

  ppvd_detector #(
    .SampleBits (SampleBits)
  ) u_det (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (det_update),
    .z_i      (z_q),
    .avg_i    (avg),
    .tenth_i  (tenth_q),
    .ts_i     (ts_q),
    .cfg_i    (cfg_q),
    .flags_o  (det_flags),
    .swing_o  (det_swing)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      tenth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_TENTH && div_done) begin
        tenth_q <= div_quo[SampleBits:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q    <= in_i.sample_value;
      ts_q      <= in_i.time_stamp;
      first_q   <= fill_q == '0;
      filling_q <= filling;
    end
    if (state_q == ST_LOAD) begin
      z_q   <= first_q ? '0 : signed'(rd0);
      neg_q <= sum_d[SumBits-1];
    end
    if (det_update) begin
      out_z_q     <= z_q;
      out_avg_q   <= avg;
      out_flags_q <= det_flags;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.delayed_sample = out_z_q;
  assign out_o.window_average = out_avg_q;
  assign out_o.peak_found     = out_flags_q.peak;
  assign out_o.valley_found   = out_flags_q.valley;

`ifndef SYNTHESIS
  // A sample is taken only while the divider is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !div_busy)
    else $error("sample accepted while divider busy");

  // The fill count never passes the window length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillBits'(WindowLen))
    else $error("fill count overflow");

  // A division finishes only while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV || state_q == ST_TENTH))
    else $error("unexpected divider completion");

  // A loaded result is presented as valid on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_update |=> out_o.valid)
    else $error("result not presented after load");
`endif

endmodule
